/* hw/rtl/u8u16_pkg.sv */
// Shared types, constants and the code point to UTF-16 conversion function.
// Used by the step, burst and top-level modules of the transcoder; depends on nothing.
package u8u16_pkg;

    localparam int UNIT_W    = 16;
    localparam int ACC_W     = 32;
    localparam int MAX_UNITS = 4;

    localparam logic [ACC_W-1:0]  CP_MAX     = 32'h0010_FFFF;
    localparam logic [ACC_W-1:0]  BMP_MAX    = 32'h0000_FFFF;
    localparam logic [20:0]       SUPP_BASE  = 21'h01_0000;
    localparam logic [UNIT_W-1:0] SURR_HIGH  = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW   = 16'hDC00;
    localparam logic [4:0]        SURR_TOP   = 5'b11011;
    localparam logic [1:0]        CONT_MARK  = 2'b10;

    typedef logic [UNIT_W-1:0] unit_t;

    // Units given by one code point: none, one, or a surrogate pair.
    typedef struct packed {
        logic [1:0] cnt;
        unit_t      first;
        unit_t      second;
    } emit_t;

    // Everything one input item produces, in output order.
    typedef struct packed {
        logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
        logic [2:0]                       count;
        logic                             last_of_text;
    } burst_t;

    function automatic emit_t emit_cp(input logic [ACC_W-1:0] cp);
        emit_t      e;
        logic [19:0] v;
        v        = 20'(cp[20:0] - SUPP_BASE);
        e.cnt    = 2'd0;
        e.first  = '0;
        e.second = '0;
        if (cp > CP_MAX)
        begin
            e.cnt = 2'd0;
        end
        else if (cp > BMP_MAX)
        begin
            e.cnt    = 2'd2;
            e.first  = SURR_HIGH | {6'b0, v[19:10]};
            e.second = SURR_LOW | {6'b0, v[9:0]};
        end
        else if (cp[15:11] == SURR_TOP)
        begin
            e.cnt = 2'd0;
        end
        else
        begin
            e.cnt   = 2'd1;
            e.first = cp[UNIT_W-1:0];
        end
        return e;
    endfunction

endpackage

/* hw/rtl/u8u16_step.sv */
// Combinational decode of one UTF-8 byte against the held code point.
// Depends on u8u16_pkg for the emit function and the burst type.
module u8u16_step (
    input  logic [u8u16_pkg::ACC_W-1:0] acc,
    input  logic                        held,
    input  logic [7:0]                  text_byte,
    input  logic                        end_of_text,
    output logic [u8u16_pkg::ACC_W-1:0] acc_next,
    output logic                        held_next,
    output u8u16_pkg::burst_t           burst
);

    logic                        cont;
    logic [u8u16_pkg::ACC_W-1:0] acc_new;
    u8u16_pkg::emit_t            first;
    u8u16_pkg::emit_t            second;
    u8u16_pkg::emit_t            held_emit;
    u8u16_pkg::emit_t            end_emit;

    assign cont      = (text_byte[7:6] == u8u16_pkg::CONT_MARK);
    assign held_emit = u8u16_pkg::emit_cp(acc);
    assign end_emit  = u8u16_pkg::emit_cp(acc_new);

    always_comb
    begin
        case (text_byte) inside
            [8'h00:8'h7F]: acc_new = {24'b0, text_byte};
            [8'h80:8'hBF]: acc_new = {acc[25:0], text_byte[5:0]};
            [8'hC0:8'hDF]: acc_new = {27'b0, text_byte[4:0]};
            [8'hE0:8'hEF]: acc_new = {28'b0, text_byte[3:0]};
            default:       acc_new = {29'b0, text_byte[2:0]};
        endcase
    end

    always_comb
    begin
        first  = '0;
        second = '0;
        if (held && !cont)
        begin
            first = held_emit;
        end
        if (end_of_text)
        begin
            second = end_emit;
        end
    end

    always_comb
    begin
        case (first.cnt)
            2'd1:    burst.units = {16'h0, second.second, second.first, first.first};
            2'd2:    burst.units = {second.second, second.first, first.second, first.first};
            default: burst.units = {16'h0, 16'h0, second.second, second.first};
        endcase
        burst.count        = {1'b0, first.cnt} + {1'b0, second.cnt};
        burst.last_of_text = end_of_text;
    end

    assign acc_next  = end_of_text ? '0 : acc_new;
    assign held_next = !end_of_text;

endmodule

/* hw/rtl/u8u16_burst.sv */
// Result register: holds one item's units, hands out one per cycle unless stalled.
// Depends on u8u16_pkg for the burst type.
module u8u16_burst (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  u8u16_pkg::burst_t        burst,
    output logic                     can_load,
    output logic                     unit_valid,
    input  logic                     unit_stall,
    output logic [u8u16_pkg::UNIT_W-1:0] code_unit,
    output logic                     run_last,
    output logic                     text_done
);

    logic [u8u16_pkg::MAX_UNITS-1:0][u8u16_pkg::UNIT_W-1:0] units_reg;
    logic [2:0] rem_reg;
    logic [2:0] rem_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       end_reg;
    logic       take;

    assign unit_valid = (rem_reg != 3'd0);
    assign take       = unit_valid && !unit_stall;
    assign can_load   = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && !unit_stall);

    assign code_unit = units_reg[idx_reg];
    assign run_last  = (rem_reg == 3'd1);
    assign text_done = (rem_reg == 3'd1) && end_reg;

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = burst.count;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            units_reg <= burst.units;
            end_reg   <= burst.last_of_text;
        end
    end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// An accepted byte goes to the input register, then its units go to the result register.
// Throughput: one byte per cycle while unit_stall is low and each byte gives
// at most one unit; a byte giving more holds the input register until the last unit.
// Reset clears the accumulator, the held flag and both valid stages at once.
// Top level: input register, accumulator state, decode step and result register.
module utf8_to_utf16_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        text_done
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [7:0]                  s1_byte_reg;
    logic                        s1_end_reg;
    logic [u8u16_pkg::ACC_W-1:0] acc_reg;
    logic [u8u16_pkg::ACC_W-1:0] acc_next;
    logic                        held_reg;
    logic                        held_next;
    logic                        can_load;
    logic                        advance;
    logic                        accept;
    u8u16_pkg::burst_t           burst;

    assign advance    = s1_valid_reg && can_load;
    assign byte_stall = s1_valid_reg && !can_load;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            held_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                acc_reg  <= acc_next;
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= text_byte;
            s1_end_reg  <= end_of_text;
        end
    end

    u8u16_step u_step (
        .acc         (acc_reg),
        .held        (held_reg),
        .text_byte   (s1_byte_reg),
        .end_of_text (s1_end_reg),
        .acc_next    (acc_next),
        .held_next   (held_next),
        .burst       (burst)
    );

    u8u16_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .burst      (burst),
        .can_load   (can_load),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .run_last   (run_last),
        .text_done  (text_done)
    );

endmodule

/* hw/rtl/u8u16_checker.sv */
// Port-level checks on the transcoder output, bound to the top level.
// Depends only on the ports of utf8_to_utf16_transcoder.
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        unit_valid,
    input logic        unit_stall,
    input logic [15:0] code_unit,
    input logic        run_last,
    input logic        text_done
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_stall |=> unit_valid && $stable(code_unit)
            && $stable(run_last) && $stable(text_done))
        else $error("stalled item changed");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && text_done |-> run_last)
        else $error("text_done without run_last");

    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && (code_unit[15:10] == 6'b110110) |-> !run_last)
        else $error("high surrogate ends a run");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_stall && (code_unit[15:10] == 6'b110110)
            |=> unit_valid && (code_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);
